// ===== design/dmhs_pkg.sv =====
// Package: shared types, constants and register indexes for the display message hold sequencer.
`default_nettype none

package dmhs_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned IDX_W  = 8;

  localparam logic [CODE_W-1:0] IDLE_CODE          = 8'h20;
  localparam logic [CODE_W-1:0] FRAME_PERIOD_RST   = 8'd20;
  localparam logic [CODE_W-1:0] MESSAGE_HOLD_RST   = 8'd25;
  localparam logic [CODE_W-1:0] RESET_HOLD_RST     = 8'd25;
  localparam logic [CODE_W-1:0] RESET_REHOLD_RST   = 8'd2;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAME_PERIOD = 8'd0,
    CFG_MESSAGE_HOLD = 8'd1,
    CFG_RESET_HOLD   = 8'd2,
    CFG_RESET_REHOLD = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] frame_period;
    logic [CODE_W-1:0] message_hold;
    logic [CODE_W-1:0] reset_hold;
    logic [CODE_W-1:0] reset_rehold;
  } cfg_regs_t;

  typedef struct packed {
    logic              unit_active;
    logic              switching_over;
    logic              reset_line;
    logic              send_request;
    logic [CODE_W-1:0] message_code;
    logic [CODE_W-1:0] station_code;
    logic [CODE_W-1:0] route_code;
    logic              door_state;
  } in_item_t;

  typedef struct packed {
    logic              frame_due;
    logic [CODE_W-1:0] message_out;
    logic [CODE_W-1:0] station_out;
    logic [CODE_W-1:0] route_out;
    logic              reset_bit;
    logic              door_bit;
    logic              reset_notice;
    logic              clear_reset;
    logic              clear_message;
    logic              ack_request;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] divider;
    logic              prev_reset;
    logic [CODE_W-1:0] prev_message;
    logic [CODE_W-1:0] reset_timer;
    logic [CODE_W-1:0] message_timer;
    logic [CODE_W-1:0] shown_message;
    logic [CODE_W-1:0] shown_station;
    logic [CODE_W-1:0] shown_route;
    logic              shown_reset;
    logic              shown_door;
    logic              notice_state;
  } frame_state_t;

endpackage

`default_nettype wire

// ===== design/dmhs_if.sv =====
// Interfaces: input item, result item and configuration write channels.
`default_nettype none

interface dmhs_in_if;
  import dmhs_pkg::*;
  logic              valid;
  logic              ready;
  logic              unit_active;
  logic              switching_over;
  logic              reset_line;
  logic              send_request;
  logic [CODE_W-1:0] message_code;
  logic [CODE_W-1:0] station_code;
  logic [CODE_W-1:0] route_code;
  logic              door_state;

  modport source (
    output valid, unit_active, switching_over, reset_line, send_request,
           message_code, station_code, route_code, door_state,
    input  ready
  );
  modport sink (
    input  valid, unit_active, switching_over, reset_line, send_request,
           message_code, station_code, route_code, door_state,
    output ready
  );
endinterface

interface dmhs_out_if;
  import dmhs_pkg::*;
  logic              valid;
  logic              ready;
  logic              frame_due;
  logic [CODE_W-1:0] message_out;
  logic [CODE_W-1:0] station_out;
  logic [CODE_W-1:0] route_out;
  logic              reset_bit;
  logic              door_bit;
  logic              reset_notice;
  logic              clear_reset;
  logic              clear_message;
  logic              ack_request;

  modport source (
    output valid, frame_due, message_out, station_out, route_out, reset_bit,
           door_bit, reset_notice, clear_reset, clear_message, ack_request,
    input  ready
  );
  modport sink (
    input  valid, frame_due, message_out, station_out, route_out, reset_bit,
           door_bit, reset_notice, clear_reset, clear_message, ack_request,
    output ready
  );
endinterface

interface dmhs_cfg_if;
  import dmhs_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  reg_index;
  logic [CODE_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ===== design/dmhs_cfg_regs.sv =====
// Configuration register file: frame period and hold times.
`default_nettype none

module dmhs_cfg_regs (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [dmhs_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [dmhs_pkg::CODE_W-1:0] wr_data,
  output dmhs_pkg::cfg_regs_t          regs
);
  import dmhs_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (wr_index)
        CFG_FRAME_PERIOD: regs_nxt.frame_period = wr_data;
        CFG_MESSAGE_HOLD: regs_nxt.message_hold = wr_data;
        CFG_RESET_HOLD:   regs_nxt.reset_hold   = wr_data;
        CFG_RESET_REHOLD: regs_nxt.reset_rehold = wr_data;
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.frame_period <= FRAME_PERIOD_RST;
      regs_r.message_hold <= MESSAGE_HOLD_RST;
      regs_r.reset_hold   <= RESET_HOLD_RST;
      regs_r.reset_rehold <= RESET_REHOLD_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// ===== design/dmhs_frame_core.sv =====
// Frame core: held frame state and the per-tick update that builds one result.
`default_nettype none

module dmhs_frame_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dmhs_pkg::cfg_regs_t cfg,
  input  wire logic                advance,
  input  wire dmhs_pkg::in_item_t  item,
  output dmhs_pkg::out_item_t      result
);
  import dmhs_pkg::*;

  frame_state_t      st_r;
  frame_state_t      st_nxt;
  logic [CODE_W-1:0] div_dec;
  logic              due;
  logic              line;
  logic [CODE_W-1:0] msg;
  logic              clr_r;
  logic              clr_m;
  logic              ack;

  // Count the divider down and gate the frame update
  assign div_dec = (st_r.divider != '0) ? st_r.divider - 1'b1 : '0;
  assign due     = (div_dec == '0) && item.unit_active && !item.switching_over;

  // Frame update: reset edge, reset timer, message take, message timer, door
  always_comb begin
    st_nxt         = st_r;
    st_nxt.divider = div_dec;
    line           = item.reset_line;
    msg            = item.message_code;
    clr_r          = 1'b0;
    clr_m          = 1'b0;
    ack            = 1'b0;

    if (due) begin
      st_nxt.divider = cfg.frame_period;

      // Reset line change: a rise arms the hold and blanks the message
      if (st_r.prev_reset != line) begin
        st_nxt.prev_reset = line;
        clr_r = 1'b1;
        if (line) begin
          st_nxt.reset_timer   = st_r.shown_reset ? cfg.reset_rehold : cfg.reset_hold;
          st_nxt.shown_reset   = 1'b1;
          st_nxt.notice_state  = 1'b1;
          st_nxt.shown_message = IDLE_CODE;
          msg   = '0;
          clr_m = 1'b1;
        end
        line = 1'b0;
      end

      // Reset hold timeout: release, or re-strobe while the line stays high
      if (st_nxt.reset_timer != '0) begin
        st_nxt.reset_timer = st_nxt.reset_timer - 1'b1;
        if (st_nxt.reset_timer == '0) begin
          if (!line) begin
            st_nxt.shown_reset  = 1'b0;
            st_nxt.notice_state = 1'b0;
          end else begin
            clr_r = 1'b1;
            st_nxt.reset_timer = 8'd1;
          end
        end
      end

      // Send request: take a changed message, latch station and route
      if (item.send_request) begin
        ack = 1'b1;
        if (st_r.prev_message != msg) begin
          st_nxt.prev_message = msg;
          if (msg != '0) begin
            st_nxt.message_timer = cfg.message_hold;
            st_nxt.shown_message = msg;
            st_nxt.shown_reset   = 1'b0;
            st_nxt.notice_state  = 1'b0;
          end
        end
        st_nxt.shown_station = item.station_code;
        st_nxt.shown_route   = item.route_code;
      end

      // Message hold timeout: revert to idle code
      if (st_nxt.message_timer != '0) begin
        st_nxt.message_timer = st_nxt.message_timer - 1'b1;
        if (st_nxt.message_timer == '0) begin
          st_nxt.shown_message = IDLE_CODE;
          st_nxt.prev_message  = '0;
          clr_m = 1'b1;
        end
      end

      st_nxt.shown_door = item.door_state;
    end
  end

  // Build the result from the updated state
  always_comb begin
    result.frame_due     = due;
    result.message_out   = st_nxt.shown_message;
    result.station_out   = st_nxt.shown_station;
    result.route_out     = st_nxt.shown_route;
    result.reset_bit     = st_nxt.shown_reset;
    result.door_bit      = st_nxt.shown_door;
    result.reset_notice  = st_nxt.notice_state;
    result.clear_reset   = clr_r;
    result.clear_message = clr_m;
    result.ack_request   = ack;
  end

  // Commit the state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.divider       <= FRAME_PERIOD_RST;
      st_r.prev_reset    <= 1'b0;
      st_r.prev_message  <= '0;
      st_r.reset_timer   <= '0;
      st_r.message_timer <= '0;
      st_r.shown_message <= IDLE_CODE;
      st_r.shown_station <= '0;
      st_r.shown_route   <= '0;
      st_r.shown_reset   <= 1'b0;
      st_r.shown_door    <= 1'b1;
      st_r.notice_state  <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTH
  // Reset bit and host notice always move together
  a_notice_tracks_reset: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.shown_reset == st_r.notice_state)
    else $error("reset bit and notice state disagree");

  // Without a frame update the divider never climbs
  a_divider_only_reloads_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !due |=> st_r.divider == $past(div_dec))
    else $error("divider moved without a frame update");

  // Hold timers only count on a frame update
  a_timers_hold_off_frame: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !due |=> $stable(st_r.reset_timer) && $stable(st_r.message_timer))
    else $error("hold timer moved without a frame update");
`endif

endmodule

`default_nettype wire

// ===== design/display_message_hold_sequencer.sv =====
// Top level: input register, frame core, result register and configuration port.
// An accepted item enters the input register, and its result is presented from the result register.
// Throughput: one item per cycle unless the result side stalls; the frame update is one pass of logic
// between the input register and the result register, and both stages hold under stall.
// Reset: synchronous active-low rst_n restores the configuration defaults,
// loads the divider with the default frame period and empties both registers.
`default_nettype none

module display_message_hold_sequencer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dmhs_in_if.sink     in_ch,
  dmhs_out_if.source  out_ch,
  dmhs_cfg_if.sink    cfg_ch
);
  import dmhs_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t res_r;
  out_item_t res_nxt;
  in_item_t  in_item;
  cfg_regs_t cfg;
  logic      advance;
  logic      in_take;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  dmhs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.data),
    .regs     (cfg)
  );

  // Pack the incoming item
  always_comb begin
    in_item.unit_active    = in_ch.unit_active;
    in_item.switching_over = in_ch.switching_over;
    in_item.reset_line     = in_ch.reset_line;
    in_item.send_request   = in_ch.send_request;
    in_item.message_code   = in_ch.message_code;
    in_item.station_code   = in_ch.station_code;
    in_item.route_code     = in_ch.route_code;
    in_item.door_state     = in_ch.door_state;
  end

  // Advance when the input stage holds an item and the result slot frees up
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  dmhs_frame_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .advance(advance),
    .item   (in_item_r),
    .result (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_due     = res_r.frame_due;
  assign out_ch.message_out   = res_r.message_out;
  assign out_ch.station_out   = res_r.station_out;
  assign out_ch.route_out     = res_r.route_out;
  assign out_ch.reset_bit     = res_r.reset_bit;
  assign out_ch.door_bit      = res_r.door_bit;
  assign out_ch.reset_notice  = res_r.reset_notice;
  assign out_ch.clear_reset   = res_r.clear_reset;
  assign out_ch.clear_message = res_r.clear_message;
  assign out_ch.ack_request   = res_r.ack_request;

`ifndef SYNTH
  // Strobes only ride on a frame update
  a_strobes_need_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.frame_due |->
      !res_r.clear_reset && !res_r.clear_message && !res_r.ack_request)
    else $error("host strobe without frame update");

  // A stalled item in the input stage is kept
  a_input_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("input item lost while stalled");

  // An untaken result is never overwritten
  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !advance)
    else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

// ===== bench/dmhs_frame_checker.sv =====
// Checker: tracks the frame sequencer from observed items and compares every result item.
`timescale 1ns / 100ps

module dmhs_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  dmhs_in_if          in_ch,
  dmhs_out_if         out_ch,
  dmhs_cfg_if         cfg_ch,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import dmhs_pkg::*;

  cfg_regs_t    regs;
  frame_state_t st;
  out_item_t    pending_frames[$];

  // Advance the sequencer by one base tick and return the frame it presents
  function automatic out_item_t advance_sequencer(in_item_t t);
    out_item_t         o;
    logic              line;
    logic [CODE_W-1:0] msg;
    o    = '0;
    line = t.reset_line;
    msg  = t.message_code;
    if (st.divider != 0) st.divider = st.divider - 1'b1;
    if (st.divider == 0 && t.unit_active && !t.switching_over) begin
      o.frame_due = 1'b1;
      st.divider  = regs.frame_period;
      // Host reset line edge; a requested clear counts as done for this frame
      if (st.prev_reset != line) begin
        st.prev_reset = line;
        o.clear_reset = 1'b1;
        line          = 1'b0;
        if (st.prev_reset) begin
          st.reset_timer   = st.shown_reset ? regs.reset_rehold : regs.reset_hold;
          st.shown_reset   = 1'b1;
          st.notice_state  = 1'b1;
          st.shown_message = IDLE_CODE;
          msg              = '0;
          o.clear_message  = 1'b1;
        end
      end
      // Reset hold countdown; keep the bit while the host line stays high
      if (st.reset_timer != 0) begin
        st.reset_timer = st.reset_timer - 1'b1;
        if (st.reset_timer == 0) begin
          if (!line) begin
            st.shown_reset  = 1'b0;
            st.notice_state = 1'b0;
          end else begin
            o.clear_reset  = 1'b1;
            line           = 1'b0;
            st.reset_timer = 8'd1;
          end
        end
      end
      // Take a send request: new nonzero message cancels the reset bit
      if (t.send_request) begin
        o.ack_request = 1'b1;
        if (st.prev_message != msg) begin
          st.prev_message = msg;
          if (msg != 0) begin
            st.message_timer = regs.message_hold;
            st.shown_message = msg;
            st.shown_reset   = 1'b0;
            st.notice_state  = 1'b0;
          end
        end
        st.shown_station = t.station_code;
        st.shown_route   = t.route_code;
      end
      // Message hold countdown; revert to idle code on expiry
      if (st.message_timer != 0) begin
        st.message_timer = st.message_timer - 1'b1;
        if (st.message_timer == 0) begin
          st.shown_message = IDLE_CODE;
          o.clear_message  = 1'b1;
          st.prev_message  = '0;
        end
      end
      st.shown_door = t.door_state;
    end
    o.message_out  = st.shown_message;
    o.station_out  = st.shown_station;
    o.route_out    = st.shown_route;
    o.reset_bit    = st.shown_reset;
    o.door_bit     = st.shown_door;
    o.reset_notice = st.notice_state;
    return o;
  endfunction

  task automatic compare_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %02h actual %02h", $time, fname, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    in_item_t  tick_in;
    if (!rst_n) begin
      regs = '{frame_period: FRAME_PERIOD_RST, message_hold: MESSAGE_HOLD_RST,
               reset_hold: RESET_HOLD_RST, reset_rehold: RESET_REHOLD_RST};
      st   = '{divider: FRAME_PERIOD_RST, prev_reset: 1'b0, prev_message: '0,
               reset_timer: '0, message_timer: '0, shown_message: IDLE_CODE,
               shown_station: '0, shown_route: '0, shown_reset: 1'b0,
               shown_door: 1'b1, notice_state: 1'b0};
      pending_frames.delete();
    end else begin
      // Compare a delivered result item with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got = '{frame_due: out_ch.frame_due, message_out: out_ch.message_out,
                station_out: out_ch.station_out, route_out: out_ch.route_out,
                reset_bit: out_ch.reset_bit, door_bit: out_ch.door_bit,
                reset_notice: out_ch.reset_notice, clear_reset: out_ch.clear_reset,
                clear_message: out_ch.clear_message, ack_request: out_ch.ack_request};
        if (pending_frames.size() == 0) begin
          $display("%0t: result item with nothing expected, actual %h", $time, got);
          mismatches = mismatches + 1;
        end else begin
          want = pending_frames.pop_front();
          compare_field("frame_due", want.frame_due, got.frame_due);
          compare_field("message_out", want.message_out, got.message_out);
          compare_field("station_out", want.station_out, got.station_out);
          compare_field("route_out", want.route_out, got.route_out);
          compare_field("reset_bit", want.reset_bit, got.reset_bit);
          compare_field("door_bit", want.door_bit, got.door_bit);
          compare_field("reset_notice", want.reset_notice, got.reset_notice);
          compare_field("clear_reset", want.clear_reset, got.clear_reset);
          compare_field("clear_message", want.clear_message, got.clear_message);
          compare_field("ack_request", want.ack_request, got.ack_request);
        end
      end
      // Apply register writes; unknown indexes are dropped
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.reg_index))
          CFG_FRAME_PERIOD: regs.frame_period = cfg_ch.data;
          CFG_MESSAGE_HOLD: regs.message_hold = cfg_ch.data;
          CFG_RESET_HOLD:   regs.reset_hold   = cfg_ch.data;
          CFG_RESET_REHOLD: regs.reset_rehold = cfg_ch.data;
          default: ;
        endcase
      end
      // Predict the frame for each accepted tick item
      if (in_ch.valid && in_ch.ready) begin
        tick_in = '{unit_active: in_ch.unit_active, switching_over: in_ch.switching_over,
                    reset_line: in_ch.reset_line, send_request: in_ch.send_request,
                    message_code: in_ch.message_code, station_code: in_ch.station_code,
                    route_code: in_ch.route_code, door_state: in_ch.door_state};
        pending_frames.push_back(advance_sequencer(tick_in));
      end
    end
    outstanding = pending_frames.size();
  end

endmodule

// ===== bench/display_message_hold_sequencer_tb.sv =====
// Testbench top: clock, reset, host mailbox stimulus, register phases and verdict.
`timescale 1ns / 100ps

module display_message_hold_sequencer_tb;
  import dmhs_pkg::*;

  localparam int               IN_W           = $bits(in_item_t);
  localparam int               PHASES         = 10;
  localparam int               PHASE_ITEMS    = 175;
  localparam int               DRAIN_CYCLES   = 4;
  localparam int               IDLE_LIMIT     = 2000;
  localparam logic [IDX_W-1:0] UNUSED_REG_IDX = 8'hFF;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned outstanding;
  int          idle_cycles;
  bit          src_busy;
  bit          sink_busy;
  in_item_t    host_box;

  dmhs_in_if  in_ch ();
  dmhs_out_if out_ch ();
  dmhs_cfg_if cfg_ch ();

  display_message_hold_sequencer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dmhs_frame_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short spans, a few long ones
  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_gap();
    if (!src_busy) return 0;
    if ($urandom_range(0, 99) < 60) return 0;
    return pick_span();
  endfunction

  // Evolve the host mailbox like a host would; some items are pure noise
  function automatic in_item_t make_item();
    in_item_t t;
    int       r;
    if ($urandom_range(0, 99) < 10) return in_item_t'(IN_W'($urandom));
    if (!host_box.reset_line && $urandom_range(0, 99) < 3) host_box.reset_line = 1'b1;
    else if (host_box.reset_line && $urandom_range(0, 99) < 2) host_box.reset_line = 1'b0;
    if (!host_box.send_request && $urandom_range(0, 99) < 20) begin
      host_box.send_request = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 15) host_box.message_code = '0;
      else if (r >= 30) host_box.message_code = CODE_W'($urandom_range(1, 255));
      host_box.station_code = CODE_W'($urandom_range(0, 255));
      host_box.route_code   = CODE_W'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 99) < 5) host_box.door_state = ~host_box.door_state;
    t = host_box;
    t.unit_active    = ($urandom_range(0, 99) < 97);
    t.switching_over = ($urandom_range(0, 99) < 4);
    return t;
  endfunction

  // Advance one clock; the host applies clear and acknowledge strobes it sees
  task automatic tick();
    @(posedge clk);
    if (out_ch.valid && out_ch.ready) begin
      if (out_ch.clear_reset) host_box.reset_line = 1'b0;
      if (out_ch.clear_message) host_box.message_code = '0;
      if (out_ch.ack_request) host_box.send_request = 1'b0;
    end
  endtask

  // Offer one tick item after an optional gap and hold it until taken
  task automatic send(input in_item_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) tick();
    end
    in_ch.unit_active    <= t.unit_active;
    in_ch.switching_over <= t.switching_over;
    in_ch.reset_line     <= t.reset_line;
    in_ch.send_request   <= t.send_request;
    in_ch.message_code   <= t.message_code;
    in_ch.station_code   <= t.station_code;
    in_ch.route_code     <= t.route_code;
    in_ch.door_state     <= t.door_state;
    in_ch.valid          <= 1'b1;
    do tick(); while (!in_ch.ready);
  endtask

  task automatic send_fields(input bit act, sw, line, req,
                             input logic [7:0] msg, stn, rte, input bit door);
    send(in_item_t'{act, sw, line, req, msg, stn, rte, door});
  endtask

  // Drop valid and wait until every predicted frame has been delivered
  task automatic drain();
    in_ch.valid <= 1'b0;
    tick();
    while (outstanding != 0) tick();
    repeat (DRAIN_CYCLES) tick();
  endtask

  task automatic write_regs(input logic [7:0] fp, mh, rh, rr, input bit with_unused);
    logic [IDX_W-1:0]  idx [5];
    logic [CODE_W-1:0] val [5];
    int                n;
    int                i;
    idx = '{CFG_FRAME_PERIOD, CFG_MESSAGE_HOLD, CFG_RESET_HOLD, CFG_RESET_REHOLD,
            UNUSED_REG_IDX};
    val = '{fp, mh, rh, rr, CODE_W'($urandom)};
    n   = with_unused ? 5 : 4;
    for (i = 0; i < n; i++) begin
      cfg_ch.reg_index <= idx[i];
      cfg_ch.data      <= val[i];
      cfg_ch.valid     <= 1'b1;
      do tick(); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side backpressure
  initial begin : sink
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if (sink_busy && $urandom_range(0, 99) < 25) begin
        stall = pick_span() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no channel moves an item for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("display_message_hold_sequencer: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] plan [5][4];
    in_item_t   t;
    int         p;
    int         k;
    plan = '{'{8'd1, 8'd5, 8'd4, 8'd2}, '{8'd2, 8'd1, 8'd1, 8'd1},
             '{8'd3, 8'd255, 8'd255, 8'd255}, '{8'd255, 8'd25, 8'd25, 8'd2},
             '{8'd1, 8'd2, 8'd3, 8'd1}};
    host_box             = '0;
    src_busy             = 1'b1;
    sink_busy            = 1'b1;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.unit_active   <= 1'b0;
    in_ch.switching_over <= 1'b0;
    in_ch.reset_line    <= 1'b0;
    in_ch.send_request  <= 1'b0;
    in_ch.message_code  <= '0;
    in_ch.station_code  <= '0;
    in_ch.route_code    <= '0;
    in_ch.door_state    <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.reg_index    <= '0;
    cfg_ch.data         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Gated ticks run the reset divider down to zero
    write_regs(8'd1, 8'd3, 8'd2, 8'd1, 1'b0);
    for (k = 0; k < 20; k++) begin
      t = in_item_t'(IN_W'($urandom));
      if (k[0]) t.unit_active = 1'b0;
      else t.switching_over = 1'b1;
      send(t);
    end
    // Field extremes, fresh reset rise, line held past the hold, fall
    send_fields(1, 0, 0, 1, 8'hFF, 8'hFF, 8'hFF, 1);
    send_fields(1, 0, 1, 0, 8'hFF, 8'h00, 8'h00, 0);
    send_fields(1, 0, 1, 0, 8'h00, 8'h00, 8'h00, 1);
    send_fields(1, 0, 1, 0, 8'h00, 8'h00, 8'h00, 0);
    send_fields(1, 0, 0, 0, 8'h00, 8'h00, 8'h00, 1);
    // Rise, fall and rise again; each rise finds the bit released and takes the hold time
    send_fields(1, 0, 1, 0, 8'h00, 8'h00, 8'h00, 1);
    send_fields(1, 0, 0, 0, 8'h00, 8'h00, 8'h00, 1);
    send_fields(1, 0, 1, 0, 8'h00, 8'h00, 8'h00, 1);
    // New message cancels reset; a repeat of it keeps the message and only updates station and route
    send_fields(1, 0, 1, 1, 8'h41, 8'h12, 8'h34, 1);
    send_fields(1, 0, 0, 1, 8'h41, 8'h56, 8'h78, 0);
    // Rise and request in one frame: message counts as cleared
    send_fields(1, 0, 1, 1, 8'h55, 8'h9A, 8'hBC, 1);
    send_fields(1, 1, 0, 0, 8'h00, 8'h00, 8'h00, 0);
    send_fields(0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
    send_fields(1, 0, 0, 1, 8'h01, 8'h00, 8'h00, 0);
    send_fields(1, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0);
    send_fields(1, 0, 0, 0, 8'h00, 8'h00, 8'h00, 1);

    // Zero period and holds: every tick a frame, nothing times out
    drain();
    write_regs(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_fields(1, 0, 1, 0, 8'h00, 8'h00, 8'h00, 1);
    send_fields(1, 0, 1, 0, 8'h00, 8'h00, 8'h00, 0);
    send_fields(1, 0, 0, 1, 8'h07, 8'h11, 8'h22, 1);
    send_fields(1, 0, 0, 1, 8'h09, 8'h33, 8'h44, 1);
    send_fields(1, 0, 1, 1, 8'h0B, 8'h55, 8'h66, 0);
    send_fields(1, 0, 0, 0, 8'h00, 8'h00, 8'h00, 1);

    // Random phases with a fresh register setting each
    for (p = 0; p < PHASES; p++) begin
      drain();
      if (p < 5) begin
        write_regs(plan[p][0], plan[p][1], plan[p][2], plan[p][3], p == 4);
      end else begin
        write_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 10)),
                   8'($urandom_range(1, 10)), 8'($urandom_range(1, 4)), 1'b0);
      end
      src_busy  = (p % 3 != 1);
      sink_busy = (p % 3 != 1);
      for (k = 0; k < PHASE_ITEMS; k++) send(make_item());
    end

    drain();
    if (mismatches == 0) begin
      $display("display_message_hold_sequencer: match");
    end else begin
      $display("display_message_hold_sequencer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dmhs_pkg.sv
design/dmhs_if.sv
design/dmhs_cfg_regs.sv
design/dmhs_frame_core.sv
design/display_message_hold_sequencer.sv
bench/dmhs_frame_checker.sv
bench/display_message_hold_sequencer_tb.sv
